// File: rtl/core/trq_pkg.sv
package trq_pkg;

  // One point or vector of three Q16.16 coordinates
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  // Per-trail bookkeeping: point count and ring head slot
  typedef struct packed {
    logic [6:0] cnt;
    logic [5:0] head;
  } meta_t;

  // Work word handed from the front end to the quad engine
  typedef struct packed {
    logic [5:0]  ent;
    logic [5:0]  head;
    logic [6:0]  cnt;
    logic [6:0]  limit;
    point_t      pos;
    logic [30:0] hw;
    logic [15:0] shader;
  } cmd_t;

endpackage

// File: rtl/core/trq_ram.sv
module trq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// File: rtl/core/trq_fifo.sv
module trq_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  trq_pkg::cmd_t push_cmd,
  input  logic          pop,
  output trq_pkg::cmd_t pop_cmd,
  output logic          full,
  output logic          empty
);
  import trq_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   count_r;

  assign full    = (count_r == (PW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign pop_cmd = mem_r[rd_ptr_r];

  // Advance pointers; depth is a power of two so they wrap by themselves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Hold words
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/core/trq_front.sv
module trq_front #(
  parameter int ENTITIES = 64,
  parameter int SEGMENTS = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  logic [1:0]     in_operation,
  input  logic [5:0]     in_entity_index,
  input  trq_pkg::point_t in_pos,
  input  logic [6:0]     in_segment_limit,
  input  logic [30:0]    in_half_width,
  input  logic [15:0]    in_shader_handle,
  input  logic           fifo_full,
  output logic           push,
  output trq_pkg::cmd_t  push_cmd
);
  import trq_pkg::*;

  localparam int ENT_USED = (ENTITIES < 64) ? ENTITIES : 64;
  localparam int EAW      = (ENT_USED > 1) ? $clog2(ENT_USED) : 1;
  localparam int SAW      = $clog2(SEGMENTS);
  localparam logic [6:0]     SEG_CNT   = 7'(SEGMENTS);
  localparam logic [SAW-1:0] HEAD_LAST = SAW'(SEGMENTS - 1);

  typedef enum logic [1:0] {
    OP_RESET  = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    F_CLEAR,
    F_IDLE,
    F_UPDATE
  } fstate_t;

  fstate_t        state_r, state_nxt;
  logic [EAW-1:0] clr_r, clr_nxt;
  cmd_t           cmd_r;
  logic [1:0]     op_r;
  logic           accept;
  logic           item_ok;
  meta_t          rd_meta;
  meta_t          wr_meta;
  logic           meta_we;
  logic [EAW-1:0] meta_waddr;
  logic [SAW-1:0] head_cur;
  logic [SAW-1:0] head_dec;
  logic [6:0]     cnt_n;
  logic [5:0]     head_n;

  trq_ram #(
    .WIDTH ($bits(meta_t)),
    .DEPTH (ENT_USED)
  ) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (wr_meta),
    .raddr (in_entity_index[EAW-1:0]),
    .rdata (rd_meta)
  );

  // Classify the incoming word
  assign busy    = (state_r != F_IDLE) || fifo_full;
  assign accept  = start && !busy;
  assign item_ok = (in_operation != OP_NONE) && (int'(in_entity_index) < ENTITIES) &&
                   ((in_operation == OP_RESET) || (in_shader_handle != 16'd0));

  // New count and head of the ring
  always_comb begin
    head_cur = rd_meta.head[SAW-1:0];
    head_dec = (head_cur == '0) ? HEAD_LAST : head_cur - 1'b1;
    cnt_n    = rd_meta.cnt;
    head_n   = 6'(head_dec);
    case (op_r)
      OP_ADD:    cnt_n = (rd_meta.cnt >= SEG_CNT) ? SEG_CNT : rd_meta.cnt + 1'b1;
      OP_REMOVE: cnt_n = (rd_meta.cnt == '0) ? '0 : rd_meta.cnt - 1'b1;
      default: begin
        cnt_n  = '0;
        head_n = rd_meta.head;
      end
    endcase
  end

  always_comb begin
    push_cmd      = cmd_r;
    push_cmd.head = head_n;
    push_cmd.cnt  = cnt_n;
  end

  // Sequence: clear pass, wait, update
  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    meta_we    = 1'b0;
    meta_waddr = cmd_r.ent[EAW-1:0];
    wr_meta    = '{cnt: cnt_n, head: head_n};
    push       = 1'b0;
    unique case (state_r)
      F_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_r;
        wr_meta    = '0;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == EAW'(ENT_USED - 1)) begin
          state_nxt = F_IDLE;
        end
      end
      F_IDLE: begin
        if (accept && item_ok) begin
          state_nxt = F_UPDATE;
        end
      end
      F_UPDATE: begin
        meta_we   = 1'b1;
        push      = (op_r != OP_RESET);
        state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r         <= in_operation;
      cmd_r.ent    <= in_entity_index;
      cmd_r.head   <= '0;
      cmd_r.cnt    <= '0;
      cmd_r.limit  <= in_segment_limit;
      cmd_r.pos    <= in_pos;
      cmd_r.hw     <= in_half_width;
      cmd_r.shader <= in_shader_handle;
    end
  end

endmodule

// File: rtl/core/trq_norm.sv
module trq_norm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic signed [63:0] vec_in [3],
  output logic               done,
  output logic signed [31:0] unit_out [3]
);

  typedef enum logic [2:0] {
    N_IDLE,
    N_SCALE,
    N_SQUARE,
    N_ROOT,
    N_DSET,
    N_DIV,
    N_DONE
  } nstate_t;

  nstate_t     state_r;
  logic        neg_r [3];
  logic [63:0] mag_r [3];
  logic [63:0] m_r;
  logic [1:0]  k_r;
  logic [63:0] sum_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;
  logic [4:0]  it_r;
  logic [31:0] drem_r;
  logic [30:0] dv_r;
  logic [30:0] q_r;
  logic        done_r;

  logic [63:0] abs_in [3];
  logic [63:0] max_in;
  logic [61:0] sq;
  logic [35:0] rem2;
  logic [35:0] trial;
  logic [61:0] dividend;
  logic [32:0] drem2;
  logic        qbit;
  logic [30:0] q_new;

  assign done = done_r;

  // Magnitudes and their maximum at launch
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      abs_in[k] = vec_in[k][63] ? 64'(-vec_in[k]) : 64'(vec_in[k]);
    end
    max_in = abs_in[0];
    if (abs_in[1] > max_in) max_in = abs_in[1];
    if (abs_in[2] > max_in) max_in = abs_in[2];
  end

  // One square, one root digit and one quotient digit per cycle
  always_comb begin
    sq       = mag_r[k_r][30:0] * mag_r[k_r][30:0];
    rem2     = {rem_r, sum_r[63:62]};
    trial    = {2'b00, root_r, 2'b01};
    dividend = {mag_r[k_r][30:0], 30'd0} + {31'd0, root_r[31:1]};
    drem2    = {drem_r, dv_r[30]};
    qbit     = (drem2 >= {1'b0, root_r});
    q_new    = {q_r[29:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == N_DONE);
      unique case (state_r)
        N_IDLE: begin
          if (go) begin
            for (int k = 0; k < 3; k++) begin
              neg_r[k] <= vec_in[k][63];
              mag_r[k] <= abs_in[k];
            end
            m_r     <= max_in;
            state_r <= N_SCALE;
          end
        end
        N_SCALE: begin
          // Bring the largest magnitude into [2^30, 2^31)
          if (m_r == '0) begin
            for (int k = 0; k < 3; k++) unit_out[k] <= '0;
            state_r <= N_DONE;
          end else if (|m_r[63:39]) begin
            m_r <= m_r >> 8;
            for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] >> 8;
          end else if (|m_r[63:31]) begin
            m_r <= m_r >> 1;
            for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] >> 1;
          end else if (m_r[30:22] == '0) begin
            m_r <= m_r << 8;
            for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] << 8;
          end else if (!m_r[30]) begin
            m_r <= m_r << 1;
            for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] << 1;
          end else begin
            k_r     <= '0;
            sum_r   <= '0;
            state_r <= N_SQUARE;
          end
        end
        N_SQUARE: begin
          sum_r <= sum_r + 64'(sq);
          k_r   <= k_r + 1'b1;
          if (k_r == 2'd2) begin
            rem_r   <= '0;
            root_r  <= '0;
            it_r    <= '0;
            state_r <= N_ROOT;
          end
        end
        N_ROOT: begin
          // Restoring square root, two radicand bits per step
          if (rem2 >= trial) begin
            rem_r  <= 34'(rem2 - trial);
            root_r <= {root_r[30:0], 1'b1};
          end else begin
            rem_r  <= rem2[33:0];
            root_r <= {root_r[30:0], 1'b0};
          end
          sum_r <= sum_r << 2;
          it_r  <= it_r + 1'b1;
          if (it_r == 5'd31) begin
            k_r     <= '0;
            state_r <= N_DSET;
          end
        end
        N_DSET: begin
          // Rounded quotient: add half the length before dividing
          drem_r  <= {1'b0, dividend[61:31]};
          dv_r    <= dividend[30:0];
          q_r     <= '0;
          it_r    <= '0;
          state_r <= N_DIV;
        end
        N_DIV: begin
          drem_r <= qbit ? 32'(drem2 - {1'b0, root_r}) : drem2[31:0];
          dv_r   <= dv_r << 1;
          q_r    <= q_new;
          it_r   <= it_r + 1'b1;
          if (it_r == 5'd30) begin
            unit_out[k_r] <= neg_r[k_r] ? -$signed({1'b0, q_new}) : $signed({1'b0, q_new});
            k_r           <= k_r + 1'b1;
            state_r       <= (k_r == 2'd2) ? N_DONE : N_DSET;
          end
        end
        N_DONE: begin
          state_r <= N_IDLE;
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/trq_back.sv
module trq_back #(
  parameter int ENTITIES = 64,
  parameter int SEGMENTS = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fifo_empty,
  output logic            pop,
  input  trq_pkg::cmd_t   cmd,
  input  trq_pkg::point_t view,
  output logic            q_valid,
  output trq_pkg::point_t q_start,
  output trq_pkg::point_t q_end,
  output trq_pkg::point_t q_side,
  output logic [5:0]      q_seg,
  output logic [15:0]     q_material,
  output logic            q_last
);
  import trq_pkg::*;

  localparam int ENT_USED = (ENTITIES < 64) ? ENTITIES : 64;
  localparam int EAW      = (ENT_USED > 1) ? $clog2(ENT_USED) : 1;
  localparam int SAW      = $clog2(SEGMENTS);
  localparam int HDEPTH   = ENT_USED * (2 ** SAW);
  localparam logic [6:0]     SEG_CNT   = 7'(SEGMENTS);
  localparam logic [SAW-1:0] SLOT_LAST = SAW'(SEGMENTS - 1);

  typedef enum logic [3:0] {
    B_IDLE,
    B_WRITE,
    B_READ,
    B_LOAD,
    B_FGO,
    B_FWAIT,
    B_CROSS,
    B_SGO,
    B_SWAIT,
    B_SIDE,
    B_EMIT
  } bstate_t;

  bstate_t            state_r;
  cmd_t               cmd_r;
  logic [SAW-1:0]     slot_r;
  logic [5:0]         seg_r;
  logic [5:0]         nq_r;
  logic [2:0]         step_r;
  logic signed [31:0] start_r [3];
  logic signed [31:0] end_r [3];
  logic signed [32:0] fwd_r [3];
  logic signed [32:0] a_r [3];
  logic signed [31:0] f_r [3];
  logic signed [63:0] cr_r [3];
  logic signed [31:0] r_r [3];
  logic signed [31:0] side_r [3];

  logic               h_we;
  logic [EAW+SAW-1:0] h_waddr;
  logic [EAW+SAW-1:0] h_raddr;
  logic [95:0]        h_rdata;
  logic [SAW-1:0]     slot_n;
  logic               norm_go;
  logic               norm_done;
  logic signed [63:0] norm_vec [3];
  logic signed [31:0] norm_unit [3];
  logic [6:0]         lim;
  logic [7:0]         cm1;
  logic [7:0]         lp1;
  logic [7:0]         nq8;
  logic [1:0]         asel;
  logic [1:0]         fsel;
  logic [1:0]         dst;
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] prod;
  logic [31:0]        umag;
  logic [62:0]        rnd;
  logic [31:0]        smag;

  trq_ram #(
    .WIDTH (96),
    .DEPTH (HDEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (cmd_r.pos),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  trq_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (norm_go),
    .vec_in   (norm_vec),
    .done     (norm_done),
    .unit_out (norm_unit)
  );

  // Ring addressing
  assign slot_n  = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
  assign h_we    = (state_r == B_WRITE);
  assign h_waddr = {cmd_r.ent[EAW-1:0], cmd_r.head[SAW-1:0]};
  assign h_raddr = {cmd_r.ent[EAW-1:0], slot_n};
  assign pop     = (state_r == B_IDLE) && !fifo_empty;

  // Quad count for this word
  always_comb begin
    lim = (cmd_r.limit > SEG_CNT) ? SEG_CNT : cmd_r.limit;
    cm1 = {1'b0, cmd_r.cnt} - 8'd1;
    lp1 = {1'b0, lim} + 8'd1;
    if (cmd_r.cnt < 7'd2) begin
      nq8 = '0;
    end else begin
      nq8 = (cm1 < lp1) ? cm1 : lp1;
    end
  end

  // Normalizer feed
  assign norm_go = (state_r == B_FGO) || (state_r == B_SGO);
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      norm_vec[k] = (state_r == B_SGO) ? cr_r[k] : 64'(fwd_r[k]);
    end
  end

  // Cross product terms: two products per component
  always_comb begin
    case (step_r)
      3'd0:    begin asel = 2'd1; fsel = 2'd2; dst = 2'd0; end
      3'd1:    begin asel = 2'd2; fsel = 2'd1; dst = 2'd0; end
      3'd2:    begin asel = 2'd2; fsel = 2'd0; dst = 2'd1; end
      3'd3:    begin asel = 2'd0; fsel = 2'd2; dst = 2'd1; end
      3'd4:    begin asel = 2'd0; fsel = 2'd1; dst = 2'd2; end
      default: begin asel = 2'd1; fsel = 2'd0; dst = 2'd2; end
    endcase
  end

  // Shared multiplier for cross product and side scaling
  always_comb begin
    umag = r_r[step_r[1:0]][31] ? 32'(-r_r[step_r[1:0]]) : 32'(r_r[step_r[1:0]]);
    if (state_r == B_SIDE) begin
      mul_a = $signed({2'b00, cmd_r.hw});
      mul_b = $signed({1'b0, umag[30:0]});
    end else begin
      mul_a = a_r[asel];
      mul_b = f_r[fsel];
    end
    prod = mul_a * mul_b;
    rnd  = {1'b0, prod[61:0]} + (63'd1 << 29);
    smag = rnd[61:30];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      q_valid <= 1'b0;
    end else begin
      q_valid <= (state_r == B_EMIT);
      unique case (state_r)
        B_IDLE: begin
          if (!fifo_empty) begin
            cmd_r   <= cmd;
            state_r <= B_WRITE;
          end
        end
        B_WRITE: begin
          // Insert the newest point, then walk the segments
          start_r[0] <= cmd_r.pos.x;
          start_r[1] <= cmd_r.pos.y;
          start_r[2] <= cmd_r.pos.z;
          slot_r     <= cmd_r.head[SAW-1:0];
          seg_r      <= '0;
          nq_r       <= nq8[5:0];
          state_r    <= (nq8 == '0) ? B_IDLE : B_READ;
        end
        B_READ: begin
          slot_r  <= slot_n;
          state_r <= B_LOAD;
        end
        B_LOAD: begin
          end_r[0] <= h_rdata[95:64];
          end_r[1] <= h_rdata[63:32];
          end_r[2] <= h_rdata[31:0];
          fwd_r[0] <= 33'($signed(h_rdata[95:64])) - 33'(start_r[0]);
          fwd_r[1] <= 33'($signed(h_rdata[63:32])) - 33'(start_r[1]);
          fwd_r[2] <= 33'($signed(h_rdata[31:0])) - 33'(start_r[2]);
          a_r[0]   <= 33'(view.x) - 33'(start_r[0]);
          a_r[1]   <= 33'(view.y) - 33'(start_r[1]);
          a_r[2]   <= 33'(view.z) - 33'(start_r[2]);
          state_r  <= B_FGO;
        end
        B_FGO: begin
          state_r <= B_FWAIT;
        end
        B_FWAIT: begin
          if (norm_done) begin
            for (int k = 0; k < 3; k++) f_r[k] <= norm_unit[k];
            step_r  <= '0;
            state_r <= B_CROSS;
          end
        end
        B_CROSS: begin
          if (!step_r[0]) begin
            cr_r[dst] <= prod[63:0];
          end else begin
            cr_r[dst] <= cr_r[dst] - prod[63:0];
          end
          step_r <= step_r + 1'b1;
          if (step_r == 3'd5) begin
            state_r <= B_SGO;
          end
        end
        B_SGO: begin
          state_r <= B_SWAIT;
        end
        B_SWAIT: begin
          if (norm_done) begin
            for (int k = 0; k < 3; k++) r_r[k] <= norm_unit[k];
            step_r  <= '0;
            state_r <= B_SIDE;
          end
        end
        B_SIDE: begin
          // Scale by half width, round half away from zero
          side_r[step_r[1:0]] <= r_r[step_r[1:0]][31] ? -$signed(smag) : $signed(smag);
          step_r <= step_r + 1'b1;
          if (step_r == 3'd2) begin
            state_r <= B_EMIT;
          end
        end
        B_EMIT: begin
          q_start    <= '{x: start_r[0], y: start_r[1], z: start_r[2]};
          q_end      <= '{x: end_r[0], y: end_r[1], z: end_r[2]};
          q_side     <= '{x: side_r[0], y: side_r[1], z: side_r[2]};
          q_seg      <= seg_r;
          q_material <= cmd_r.shader;
          q_last     <= (seg_r == nq_r - 1'b1);
          for (int k = 0; k < 3; k++) start_r[k] <= end_r[k];
          seg_r      <= seg_r + 1'b1;
          state_r    <= (seg_r == nq_r - 1'b1) ? B_IDLE : B_READ;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/trail_ribbon_quad_generator.sv
// Ribbon trail quad generator. Words enter on start while busy is low; each
// resets, extends or shortens one trail's point ring. The front end updates
// the trail's count and head and queues each valid word but a reset; the quad
// engine then writes the ring and runs, per emitted quad, two vector
// normalizations on a shared bit-serial unit (a 32-step square root and
// three 31-step divisions each), cut short when a vector is zero. A word
// whose trail holds n >= 2 points after the update yields min(n-1, limit+1)
// quads, strobed on out_valid one cycle each, with out_last_quad on the
// final one; the receiver cannot stall them. After reset, busy stays high
// while the trail counts are cleared.
module trail_ribbon_quad_generator #(
  parameter int ENTITIES = 64,
  parameter int SEGMENTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [5:0]         in_entity_index,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [6:0]         in_segment_limit,
  input  logic [30:0]        in_half_width,
  input  logic [15:0]        in_shader_handle,
  output logic               out_valid,
  output logic signed [31:0] out_start_x,
  output logic signed [31:0] out_start_y,
  output logic signed [31:0] out_start_z,
  output logic signed [31:0] out_end_x,
  output logic signed [31:0] out_end_y,
  output logic signed [31:0] out_end_z,
  output logic signed [31:0] out_side_x,
  output logic signed [31:0] out_side_y,
  output logic signed [31:0] out_side_z,
  output logic [5:0]         out_segment_number,
  output logic [15:0]        out_material,
  output logic               out_last_quad,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import trq_pkg::*;

  localparam logic [7:0] COLOR_RESET = 8'd255;

  typedef enum logic [2:0] {
    CFG_VIEW_X      = 3'd0,
    CFG_VIEW_Y      = 3'd1,
    CFG_VIEW_Z      = 3'd2,
    CFG_COLOR_RED   = 3'd3,
    CFG_COLOR_GREEN = 3'd4,
    CFG_COLOR_BLUE  = 3'd5
  } cfg_idx_t;

  point_t     view_r;
  logic [7:0] color_red_r;
  logic [7:0] color_green_r;
  logic [7:0] color_blue_r;

  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;
  cmd_t   q_in;
  cmd_t   q_out;
  point_t in_pos;
  point_t o_start;
  point_t o_end;
  point_t o_side;

  assign cfg_ready = 1'b1;
  assign in_pos    = '{x: in_pos_x, y: in_pos_y, z: in_pos_z};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_r        <= '0;
      color_red_r   <= COLOR_RESET;
      color_green_r <= COLOR_RESET;
      color_blue_r  <= COLOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_VIEW_X:      view_r.x      <= cfg_data;
        CFG_VIEW_Y:      view_r.y      <= cfg_data;
        CFG_VIEW_Z:      view_r.z      <= cfg_data;
        CFG_COLOR_RED:   color_red_r   <= cfg_data[7:0];
        CFG_COLOR_GREEN: color_green_r <= cfg_data[7:0];
        CFG_COLOR_BLUE:  color_blue_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  trq_front #(
    .ENTITIES (ENTITIES),
    .SEGMENTS (SEGMENTS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_entity_index  (in_entity_index),
    .in_pos           (in_pos),
    .in_segment_limit (in_segment_limit),
    .in_half_width    (in_half_width),
    .in_shader_handle (in_shader_handle),
    .fifo_full        (q_full),
    .push             (q_push),
    .push_cmd         (q_in)
  );

  trq_fifo #(
    .DEPTH (4)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in),
    .pop      (q_pop),
    .pop_cmd  (q_out),
    .full     (q_full),
    .empty    (q_empty)
  );

  trq_back #(
    .ENTITIES (ENTITIES),
    .SEGMENTS (SEGMENTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (q_empty),
    .pop        (q_pop),
    .cmd        (q_out),
    .view       (view_r),
    .q_valid    (out_valid),
    .q_start    (o_start),
    .q_end      (o_end),
    .q_side     (o_side),
    .q_seg      (out_segment_number),
    .q_material (out_material),
    .q_last     (out_last_quad)
  );

  assign out_start_x = o_start.x;
  assign out_start_y = o_start.y;
  assign out_start_z = o_start.z;
  assign out_end_x   = o_end.x;
  assign out_end_y   = o_end.y;
  assign out_end_z   = o_end.z;
  assign out_side_x  = o_side.x;
  assign out_side_y  = o_side.y;
  assign out_side_z  = o_side.z;

  // Quads are far apart: never two strobes in a row
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back quad strobes");

  // Words with a zero material never reach the quad engine
  a_material: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_material != 16'd0))
    else $error("quad with zero material");

  // The queue is never pushed while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue overflow");

  // A full queue holds the input off
  a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> busy)
    else $error("input open while queue full");

endmodule
